// ----- src/pbsa_pkg.sv -----
// shared types, codes and constants for the bar sizing and address allocation unit
`timescale 1ns / 1ps
`default_nettype none
package pbsa_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam logic [63:0] ADDR_MAX = 64'((65'd1 << ADDR_W) - 65'd1);

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 192;

  // request kinds
  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_PROBE = 2'd1;
  localparam logic [1:0] FUNC_OPEN  = 2'd2;
  localparam logic [1:0] FUNC_CLOSE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MASK = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_NO_FIT   = 2'd3;

  // pool kinds
  localparam logic [1:0] KIND_IO   = 2'd0;
  localparam logic [1:0] KIND_PREF = 2'd1;
  localparam logic [1:0] KIND_MEM  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MEM_START  = 3'd0;
  localparam logic [2:0] CFG_MEM_END    = 3'd1;
  localparam logic [2:0] CFG_PREF_START = 3'd2;
  localparam logic [2:0] CFG_PREF_END   = 3'd3;
  localparam logic [2:0] CFG_IO_START   = 3'd4;
  localparam logic [2:0] CFG_IO_END     = 3'd5;
  localparam logic [2:0] CFG_ASSIGN     = 3'd6;

  localparam logic [31:0] IO_SIZE_MASK  = 32'hffff_fffe;
  localparam logic [31:0] MEM_SIZE_MASK = 32'hffff_fff0;
  localparam logic [31:0] IO_ADDR_MASK  = 32'hffff_fffc;
  localparam logic [31:0] MEM_ADDR_MASK = 32'hffff_fff0;
  localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;

  typedef struct packed {
    logic [63:0] mem_start;
    logic [63:0] mem_end;
    logic [63:0] pref_start;
    logic [63:0] pref_end;
    logic [63:0] io_start;
    logic [63:0] io_end;
    logic        assign_mode;
  } cfg_t;

  // classified request between front and back
  typedef struct packed {
    logic [1:0]  func;
    logic        bad_mask;
    logic        zero_size;
    logic        is_io;
    logic        pref_bit;
    logic        wide;
    logic [31:0] size;
    logic [63:0] dec_start;
    logic [63:0] dec_end;
  } req_t;

  typedef struct packed {
    logic        io_valid;
    logic [15:0] io_high;
    logic [7:0]  io_low;
    logic        pref_valid;
    logic [15:0] pref_word;
    logic        mem_valid;
    logic [15:0] mem_word;
    logic [63:0] range_end;
    logic [63:0] range_start;
    logic        is_wide;
    logic [1:0]  status;
  } res_t;

endpackage
`default_nettype wire

// ----- src/pbsa_front.sv -----
// front end: bar sizing, mask checks and decode address for each request
`timescale 1ns / 1ps
`default_nettype none
module pbsa_front (
  input  wire logic [1:0]  func,
  input  wire logic [31:0] bar_original,
  input  wire logic [31:0] bar_mask,
  input  wire logic [31:0] bar_upper,
  output pbsa_pkg::req_t   req
);

  logic [31:0] size_mask;
  logic [31:0] masked;
  logic [31:0] low_bit;
  logic [31:0] size;
  logic        io;
  logic        wide;
  logic [63:0] start;
  logic [63:0] last;

  always_comb begin
    io        = bar_mask[0];
    wide      = bar_mask[2];
    size_mask = io ? pbsa_pkg::IO_SIZE_MASK : pbsa_pkg::MEM_SIZE_MASK;
    masked    = bar_mask & size_mask;
    low_bit   = masked & (~masked + 32'd1);
    if (masked == 32'd0) begin
      size = 32'd0;
    end else if (bar_original == bar_mask &&
                 ((bar_original | (low_bit - 32'd1)) & size_mask) != size_mask) begin
      size = 32'd0;
    end else begin
      size = low_bit;
    end
    start = {wide ? bar_upper : 32'd0,
             bar_original & (io ? pbsa_pkg::IO_ADDR_MASK : pbsa_pkg::MEM_ADDR_MASK)};
    start = start & pbsa_pkg::ADDR_MAX;
    last  = (start + {32'd0, size - 32'd1}) & pbsa_pkg::ADDR_MAX;

    req.func      = func;
    req.bad_mask  = (bar_mask == 32'd0) || (bar_mask == pbsa_pkg::ALL_ONES);
    req.zero_size = (size == 32'd0);
    req.is_io     = io;
    req.pref_bit  = bar_mask[3];
    req.wide      = wide;
    req.size      = size;
    req.dec_start = start;
    req.dec_end   = last;
  end

endmodule
`default_nettype wire

// ----- src/pbsa_queue.sv -----
// two-entry request queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module pbsa_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pbsa_pkg::req_t  push_req,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output pbsa_pkg::req_t       head_req
);

  pbsa_pkg::req_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_req   = entry_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && head_valid;
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule
`default_nettype wire

// ----- src/pbsa_back.sv -----
// back end: pool cursors, placement, bridge window words and result register
`timescale 1ns / 1ps
`default_nettype none
module pbsa_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pbsa_pkg::cfg_t  cfg,
  input  wire logic            head_valid,
  input  wire pbsa_pkg::req_t  head_req,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pbsa_pkg::res_t       out_res,
  output logic [1:0]           out_kind
);

  logic [63:0] mem_cur_r, mem_cur_nxt;
  logic [63:0] pref_cur_r, pref_cur_nxt;
  logic [63:0] io_cur_r, io_cur_nxt;
  logic        out_valid_r, out_valid_nxt;
  pbsa_pkg::res_t res_r, res_nxt;
  logic [1:0]  kind_r, kind_nxt;

  logic [1:0]  kind;
  logic [63:0] cur;
  logic [63:0] wstart;
  logic [63:0] wend;
  logic [63:0] lim;
  logic [63:0] smask;
  logic [64:0] sum;
  logic [63:0] aligned;
  logic [63:0] last;
  logic        fit;
  logic        close;
  logic [43:0] mem_up;
  logic [43:0] pref_up;
  logic [51:0] io_up;
  logic [11:0] mem_w;
  logic [11:0] pref_w;
  logic [19:0] io_w;

  assign pop       = head_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;
  assign out_kind  = kind_r;

  always_comb begin
    // pool choice and placement
    if (head_req.is_io) begin
      kind = pbsa_pkg::KIND_IO;   cur = io_cur_r;
      wstart = cfg.io_start;      wend = cfg.io_end;
    end else if (head_req.pref_bit && pref_cur_r != 64'd0) begin
      kind = pbsa_pkg::KIND_PREF; cur = pref_cur_r;
      wstart = cfg.pref_start;    wend = cfg.pref_end;
    end else begin
      kind = pbsa_pkg::KIND_MEM;  cur = mem_cur_r;
      wstart = cfg.mem_start;     wend = cfg.mem_end;
    end
    lim     = (wend < pbsa_pkg::ADDR_MAX) ? wend : pbsa_pkg::ADDR_MAX;
    smask   = {32'd0, head_req.size - 32'd1};
    sum     = {1'b0, cur} + {1'b0, smask};
    aligned = sum[63:0] & ~smask;
    last    = aligned | smask;
    fit     = (wstart != 64'd0) && !sum[64] && (last <= lim);

    // bridge alignment
    close   = (head_req.func == pbsa_pkg::FUNC_CLOSE);
    mem_up  = mem_cur_r[63:20] + {43'd0, |mem_cur_r[19:0]};
    pref_up = pref_cur_r[63:20] + {43'd0, |pref_cur_r[19:0]};
    io_up   = io_cur_r[63:12] + {51'd0, |io_cur_r[11:0]};
    mem_w   = close ? mem_up[11:0] - 12'd1 : mem_up[11:0];
    pref_w  = close ? pref_up[11:0] - 12'd1 : pref_up[11:0];
    io_w    = close ? io_up[19:0] - 20'd1 : io_up[19:0];

    mem_cur_nxt   = mem_cur_r;
    pref_cur_nxt  = pref_cur_r;
    io_cur_nxt    = io_cur_r;
    res_nxt       = '0;
    kind_nxt      = pbsa_pkg::KIND_IO;
    out_valid_nxt = out_valid_r && !out_ready;

    if (pop) begin
      out_valid_nxt = 1'b1;
      case (head_req.func)
        pbsa_pkg::FUNC_BEGIN: begin
          mem_cur_nxt  = cfg.mem_start;
          pref_cur_nxt = cfg.pref_start;
          io_cur_nxt   = cfg.io_start;
        end
        pbsa_pkg::FUNC_PROBE: begin
          if (head_req.bad_mask) begin
            res_nxt.status = pbsa_pkg::ST_BAD_MASK;
          end else begin
            kind_nxt = kind;
            if (head_req.zero_size) begin
              res_nxt.status = pbsa_pkg::ST_ZERO;
            end else if (!cfg.assign_mode) begin
              res_nxt.status      = pbsa_pkg::ST_OK;
              res_nxt.is_wide     = head_req.wide;
              res_nxt.range_start = head_req.dec_start;
              res_nxt.range_end   = head_req.dec_end;
            end else if (!fit) begin
              res_nxt.status = pbsa_pkg::ST_NO_FIT;
            end else begin
              res_nxt.status      = pbsa_pkg::ST_OK;
              res_nxt.is_wide     = head_req.wide;
              res_nxt.range_start = aligned;
              res_nxt.range_end   = last;
              case (kind)
                pbsa_pkg::KIND_IO:   io_cur_nxt   = last + 64'd1;
                pbsa_pkg::KIND_PREF: pref_cur_nxt = last + 64'd1;
                default:             mem_cur_nxt  = last + 64'd1;
              endcase
            end
          end
        end
        default: begin
          if (mem_cur_r != 64'd0) begin
            mem_cur_nxt       = {mem_up, 20'd0};
            res_nxt.mem_word  = {mem_w, 4'd0};
            res_nxt.mem_valid = 1'b1;
          end
          if (pref_cur_r != 64'd0) begin
            pref_cur_nxt       = {pref_up, 20'd0};
            res_nxt.pref_word  = {pref_w, 4'd0};
            res_nxt.pref_valid = 1'b1;
          end
          if (io_cur_r != 64'd0) begin
            io_cur_nxt       = {io_up, 12'd0};
            res_nxt.io_low   = {io_w[3:0], 4'd0};
            res_nxt.io_high  = io_w[19:4];
            res_nxt.io_valid = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_cur_r   <= 64'd0;
      pref_cur_r  <= 64'd0;
      io_cur_r    <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      mem_cur_r   <= mem_cur_nxt;
      pref_cur_r  <= pref_cur_nxt;
      io_cur_r    <= io_cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r  <= res_nxt;
      kind_r <= kind_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/pci_bar_size_and_assign_unit.sv -----
// top level of the pci bar sizing and address allocation unit
`timescale 1ns / 1ps
`default_nettype none
// One request in, one result out. Request kinds in in_tuser: begin loads the
// three pool cursors (plain memory, prefetchable, I/O) from their window
// starts; a BAR probe sizes the BAR from the read-back value and either places
// it at the next naturally aligned cursor position (assign mode) or decodes
// the address already in the BAR; bridge open and close round the live cursors
// up to 1 MiB / 4 KiB and return the bridge base or limit words. A request is
// classified in the front end as it is taken, waits in a two-entry queue and
// is carried out by the back end, which owns the cursors and registers the
// result. The unit sustains one request per cycle while out_tready is high.
// Window registers and assign mode are to be written through the cfg port
// while no request is in flight; the unit itself does not enforce this.
module pci_bar_size_and_assign_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // bar_original[31:0], bar_mask[63:32], bar_upper[95:64]
  input  wire logic [pbsa_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[1:0], is_wide[2], range_start[66:3], range_end[130:67],
  // mem_word[146:131], mem_valid[147], pref_word[163:148], pref_valid[164],
  // io_low[172:165], io_high[188:173], io_valid[189], zero pad[191:190]
  output logic [pbsa_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind[1:0]
  output logic [1:0]        out_tuser
);

  pbsa_pkg::cfg_t cfg_r, cfg_nxt;
  pbsa_pkg::req_t front_req;
  pbsa_pkg::req_t head_req;
  pbsa_pkg::res_t res;
  logic           q_full;
  logic           head_valid;
  logic           pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        pbsa_pkg::CFG_MEM_START:  cfg_nxt.mem_start   = cfg_wdata;
        pbsa_pkg::CFG_MEM_END:    cfg_nxt.mem_end     = cfg_wdata;
        pbsa_pkg::CFG_PREF_START: cfg_nxt.pref_start  = cfg_wdata;
        pbsa_pkg::CFG_PREF_END:   cfg_nxt.pref_end    = cfg_wdata;
        pbsa_pkg::CFG_IO_START:   cfg_nxt.io_start    = cfg_wdata;
        pbsa_pkg::CFG_IO_END:     cfg_nxt.io_end      = cfg_wdata;
        pbsa_pkg::CFG_ASSIGN:     cfg_nxt.assign_mode = cfg_wdata[0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pbsa_front u_front (
    .func         (in_tuser),
    .bar_original (in_tdata[31:0]),
    .bar_mask     (in_tdata[63:32]),
    .bar_upper    (in_tdata[95:64]),
    .req          (front_req)
  );

  assign in_tready = !q_full;

  pbsa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid),
    .push_req   (front_req),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  pbsa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res),
    .out_kind   (out_tuser)
  );

  assign out_tdata = {2'b00, res};

endmodule
`default_nettype wire
